/* design/ssmt_pkg.sv */
// Shared constants, codes and types for the set membership table.
package ssmt_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;
    localparam int KIND_W   = 2;
    localparam int STAT_W   = 2;
    localparam int OCNT_W   = 5;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TEST   = 2'd2;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE    = 2'd0,
        ST_PRESENT = 2'd1,
        ST_FULL    = 2'd2,
        ST_ABSENT  = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    // Update commands broadcast to every cell of the chain.
    typedef struct packed {
        logic             do_insert;
        logic             do_remove;
        logic [IDX_W-1:0] slot;
    } t_cell_ctl;

endpackage

/* design/small_set_membership_table_core.sv */
// Top level of the set membership table: request capture, cell chain and result.
//
// Usage:
//   A request word (i_kind, i_item_value) is taken at a rising edge where
//   i_start is high and o_busy is low. i_kind: insert, remove or test
//   (the unused code acts as a test).
//   The request is executed in the following cycle: every cell compares its
//   entry with the value in parallel, and on insert or remove the cells load
//   or shift down in that same cycle.
//   The result word (o_status, o_was_present, o_entry_count) is shown for
//   exactly one cycle with o_valid high. It is registered at the end of the
//   execute cycle and is taken at the edge that ends its valid cycle.
//   o_busy is high during the execute cycle only, so a new request is taken
//   in the cycle the previous result is shown. No new request is taken while
//   one executes: each takes one compare-and-update pass over the cell chain.
//   The receiver cannot stall; results are not held.
//   Reset clears the entry count and the control state; the table contents
//   are don't-care until written and need no clearing pass.
module small_set_membership_table_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    output logic                                o_busy,
    input  logic [ssmt_pkg::KIND_W-1:0]         i_kind,
    input  logic signed [ssmt_pkg::VAL_W-1:0]   i_item_value,
    output logic                                o_valid,
    output logic [ssmt_pkg::STAT_W-1:0]         o_status,
    output logic                                o_was_present,
    output logic [ssmt_pkg::OCNT_W-1:0]         o_entry_count
);
    import ssmt_pkg::*;

    t_state                  r_state, n_state;
    logic [KIND_W-1:0]       r_kind;
    logic signed [VAL_W-1:0] r_value;
    logic [CNT_W-1:0]        r_count, n_count;
    logic                    r_valid, n_valid;
    t_status                 r_status, n_status;
    logic                    r_present;
    logic [OCNT_W-1:0]       r_out_count;

    logic [CAPACITY-1:0]     w_match;
    logic signed [VAL_W-1:0] w_entry [CAPACITY+1];
    logic                    w_present;
    logic [IDX_W-1:0]        w_slot;
    logic                    w_full;
    logic                    w_accept;
    t_cell_ctl               w_ctl;
    logic [CNT_W+OCNT_W-1:0] w_count_ext;

    assign o_busy   = (r_state == S_EXEC);
    assign w_accept = i_start && !o_busy;

    assign w_entry[CAPACITY] = '0;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            ssmt_cell u_cell (
                .i_clk        (i_clk),
                .i_index      (IDX_W'(g)),
                .i_value      (r_value),
                .i_count      (r_count),
                .i_ctl        (w_ctl),
                .i_next_entry (w_entry[g+1]),
                .o_entry      (w_entry[g]),
                .o_match      (w_match[g])
            );
        end
    endgenerate

    // entries are distinct, so at most one cell matches: OR its index out
    always_comb begin
        w_slot = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (w_match[i]) begin
                w_slot = w_slot | IDX_W'(i);
            end
        end
    end

    assign w_present = |w_match;
    assign w_full    = r_count >= CNT_W'(CAPACITY);

    always_comb begin
        n_state         = r_state;
        n_count         = r_count;
        n_valid         = 1'b0;
        n_status        = ST_DONE;
        w_ctl.do_insert = 1'b0;
        w_ctl.do_remove = 1'b0;
        w_ctl.slot      = w_slot;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                n_valid = 1'b1;
                case (r_kind)
                    KIND_INSERT: begin
                        if (w_present) begin
                            n_status = ST_PRESENT;
                        end else if (w_full) begin
                            n_status = ST_FULL;
                        end else begin
                            w_ctl.do_insert = 1'b1;
                            n_count         = r_count + 1'b1;
                        end
                    end
                    KIND_REMOVE: begin
                        if (!w_present) begin
                            n_status = ST_ABSENT;
                        end else begin
                            w_ctl.do_remove = 1'b1;
                            n_count         = r_count - 1'b1;
                        end
                    end
                    default: begin
                        n_status = ST_DONE;
                    end
                endcase
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign w_count_ext = {{OCNT_W{1'b0}}, n_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind  <= i_kind;
            r_value <= i_item_value;
        end
        if (r_state == S_EXEC) begin
            r_status    <= n_status;
            r_present   <= w_present;
            r_out_count <= w_count_ext[OCNT_W-1:0];
        end
    end

    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_was_present = r_present;
    assign o_entry_count = r_out_count;

endmodule

/* design/ssmt_cell.sv */
// One table cell: holds an entry, matches it against the request, shifts or loads it.
module ssmt_cell (
    input  logic                          i_clk,
    input  logic [ssmt_pkg::IDX_W-1:0]    i_index,
    input  logic signed [ssmt_pkg::VAL_W-1:0] i_value,
    input  logic [ssmt_pkg::CNT_W-1:0]    i_count,
    input  ssmt_pkg::t_cell_ctl           i_ctl,
    input  logic signed [ssmt_pkg::VAL_W-1:0] i_next_entry,
    output logic signed [ssmt_pkg::VAL_W-1:0] o_entry,
    output logic                          o_match
);
    import ssmt_pkg::*;

    logic signed [VAL_W-1:0] r_entry;
    logic signed [VAL_W-1:0] n_entry;
    logic                    w_live;

    assign w_live  = CNT_W'(i_index) < i_count;
    assign o_match = w_live && (r_entry == i_value);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.do_remove && (i_index >= i_ctl.slot)) begin
            // take the word from the upper neighbor to close the gap
            n_entry = i_next_entry;
        end else if (i_ctl.do_insert && (CNT_W'(i_index) == i_count)) begin
            n_entry = i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule
